// ----- hdl/ffa_pkg.sv -----
// Package for the forest fire grid automaton.
// Holds cell and command codes and the controller to datapath command word.
// No dependencies.
package ffa_pkg;

    localparam int FUNC_W = 2;
    localparam int FIELD_IDX_W = 4;
    localparam int FIELD_CELLS = 16;
    localparam int CELL_W = 2;
    localparam int ROW_CELLS_W = FIELD_CELLS * CELL_W;

    localparam logic [CELL_W-1:0] CELL_ALIVE   = 2'd0;
    localparam logic [CELL_W-1:0] CELL_BURNING = 2'd1;
    localparam logic [CELL_W-1:0] CELL_BURNED  = 2'd2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_IGNITE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

    typedef struct packed {
        logic load;
        logic upd_step;
        logic emit_step;
        logic emit_load;
        logic head;
        logic tail;
        logic emit_last;
    } ffa_cmd_t;

endpackage

// ----- hdl/ffa_cmd_if.sv -----
// Command channel of the forest fire grid automaton.
// Depends on ffa_pkg.
interface ffa_cmd_if
    import ffa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FUNC_W-1:0]      func;
    logic [FIELD_IDX_W-1:0] cell_row;
    logic [FIELD_IDX_W-1:0] cell_col;

    modport source (output valid, output func, output cell_row, output cell_col,
                    input ready);
    modport sink (input valid, input func, input cell_row, input cell_col,
                  output ready);
endinterface

// ----- hdl/ffa_row_if.sv -----
// Row result channel of the forest fire grid automaton.
// Depends on ffa_pkg.
interface ffa_row_if
    import ffa_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FIELD_IDX_W-1:0] row_index;
    logic [ROW_CELLS_W-1:0] row_cells;
    logic                   any_burning;
    logic                   last_row;

    modport source (output valid, output row_index, output row_cells,
                    output any_burning, output last_row, input ready);
    modport sink (input valid, input row_index, input row_cells,
                  input any_burning, input last_row, output ready);
endinterface

// ----- hdl/forest_fire_grid_automaton.sv -----
// Forest fire grid automaton: a GRID_SIZE square grid of cells that is
// cleared, ignited at one cell or advanced one generation per command word,
// after which the grid goes out one row word at a time (at most the first 16
// rows, at most 16 cells each). The grid circulates through a line of row
// registers, one row per cycle while the row output is not stalled: a command
// is taken, an update pass moves all GRID_SIZE rows through the row update
// logic, then an emit pass moves them round again and loads the row words.
// A new command is taken only after the emit pass has gone round all rows,
// at the default size once the last row word sits in the output register.
// Depends on ffa_pkg, ffa_cmd_if, ffa_row_if, ffa_ctrl and ffa_datapath.
module forest_fire_grid_automaton
    import ffa_pkg::*;
#(
    parameter int GRID_SIZE = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    ffa_cmd_if.sink   cmd,
    ffa_row_if.source rows
);
    ffa_cmd_t                     ctl;
    logic [$clog2(GRID_SIZE)-1:0] row_idx;
    logic                         out_free;

    ffa_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .out_free  (out_free),
        .ctl       (ctl),
        .row_idx   (row_idx)
    );

    ffa_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .row_idx         (row_idx),
        .func            (cmd.func),
        .cell_row        (cmd.cell_row),
        .cell_col        (cmd.cell_col),
        .out_free        (out_free),
        .out_valid       (rows.valid),
        .out_ready       (rows.ready),
        .out_row_index   (rows.row_index),
        .out_row_cells   (rows.row_cells),
        .out_any_burning (rows.any_burning),
        .out_last_row    (rows.last_row)
    );

endmodule

// ----- hdl/ffa_ctrl.sv -----
// Sequencer of the forest fire grid automaton: update pass, then emit pass.
// Depends on ffa_pkg.
module ffa_ctrl
    import ffa_pkg::*;
#(
    parameter int GRID_SIZE = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic                         out_free,
    output ffa_cmd_t                     ctl,
    output logic [$clog2(GRID_SIZE)-1:0] row_idx
);
    localparam int ROW_W = $clog2(GRID_SIZE);
    localparam int EMIT_ROWS = (GRID_SIZE < FIELD_CELLS) ? GRID_SIZE : FIELD_CELLS;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_UPDATE = 3'b010,
        ST_EMIT   = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             at_tail;
    logic             emitting;

    assign at_tail  = (row_reg == ROW_W'(GRID_SIZE - 1));
    assign emitting = ((ROW_W + 1)'(row_reg) < (ROW_W + 1)'(EMIT_ROWS));
    assign cmd_ready = (state_reg == ST_IDLE);
    assign row_idx = row_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        ctl        = '0;
        ctl.head      = (row_reg == '0);
        ctl.tail      = at_tail;
        ctl.emit_last = (row_reg == ROW_W'(EMIT_ROWS - 1));
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    row_next   = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                ctl.upd_step = 1'b1;
                if (at_tail)
                begin
                    row_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!emitting || out_free)
                begin
                    ctl.emit_step = 1'b1;
                    ctl.emit_load = emitting;
                    if (at_tail)
                    begin
                        row_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule

// ----- hdl/ffa_datapath.sv -----
// Grid store as a circulating line of rows, row update logic and output word.
// Depends on ffa_pkg.
module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int GRID_SIZE = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffa_cmd_t                     ctl,
    input  logic [$clog2(GRID_SIZE)-1:0] row_idx,
    input  logic [FUNC_W-1:0]            func,
    input  logic [FIELD_IDX_W-1:0]       cell_row,
    input  logic [FIELD_IDX_W-1:0]       cell_col,
    output logic                         out_free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [FIELD_IDX_W-1:0]       out_row_index,
    output logic [ROW_CELLS_W-1:0]       out_row_cells,
    output logic                         out_any_burning,
    output logic                         out_last_row
);
    localparam int ROW_W = $clog2(GRID_SIZE);
    localparam int IDX_W = (ROW_W > FIELD_IDX_W) ? ROW_W : FIELD_IDX_W;
    localparam int LINE_W = GRID_SIZE * CELL_W;
    localparam int EMIT_COLS = (GRID_SIZE < FIELD_CELLS) ? GRID_SIZE : FIELD_CELLS;

    logic [LINE_W-1:0]      rows_reg [GRID_SIZE];
    logic [LINE_W-1:0]      rows_next [GRID_SIZE];
    logic [LINE_W-1:0]      prev_reg, prev_next;
    logic [FUNC_W-1:0]      func_reg;
    logic [FIELD_IDX_W-1:0] crow_reg;
    logic [FIELD_IDX_W-1:0] ccol_reg;
    logic                   burn_reg, burn_next;

    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_IDX_W-1:0] out_idx_reg;
    logic [ROW_CELLS_W-1:0] out_cells_reg, out_cells_next;
    logic                   out_burn_reg;
    logic                   out_last_reg;

    logic [LINE_W-1:0]      cur_row;
    logic [LINE_W-1:0]      new_row;
    logic [GRID_SIZE-1:0]   prev_mask, cur_mask, below_mask, new_mask, near;

    function automatic logic [GRID_SIZE-1:0] burn_mask(input logic [LINE_W-1:0] r);
        logic [GRID_SIZE-1:0] m;
        for (int j = 0; j < GRID_SIZE; j++)
        begin
            m[j] = (r[j*CELL_W +: CELL_W] == CELL_BURNING);
        end
        return m;
    endfunction

    function automatic logic [GRID_SIZE-1:0] spread(input logic [GRID_SIZE-1:0] m);
        return m | (m << 1) | (m >> 1);
    endfunction

    assign cur_row    = rows_reg[0];
    assign prev_mask  = ctl.head ? '0 : burn_mask(prev_reg);
    assign below_mask = ctl.tail ? '0 : burn_mask(rows_reg[(GRID_SIZE > 1) ? 1 : 0]);
    assign cur_mask   = burn_mask(cur_row);
    assign near       = spread(prev_mask) | spread(below_mask) | (cur_mask << 1)
                      | (cur_mask >> 1);

    always_comb
    begin
        logic [CELL_W-1:0] c;
        new_row = cur_row;
        c       = '0;
        unique case (func_reg)
            FUNC_CLEAR:
            begin
                new_row = '0;
            end
            FUNC_IGNITE:
            begin
                if (IDX_W'(crow_reg) == IDX_W'(row_idx))
                begin
                    for (int j = 0; j < GRID_SIZE; j++)
                    begin
                        if (IDX_W'(ccol_reg) == IDX_W'(j))
                        begin
                            new_row[j*CELL_W +: CELL_W] = CELL_BURNING;
                        end
                    end
                end
            end
            FUNC_ADVANCE:
            begin
                for (int j = 0; j < GRID_SIZE; j++)
                begin
                    c = cur_row[j*CELL_W +: CELL_W];
                    if (c == CELL_ALIVE && near[j])
                    begin
                        new_row[j*CELL_W +: CELL_W] = CELL_BURNING;
                    end
                    else if (c == CELL_BURNING)
                    begin
                        new_row[j*CELL_W +: CELL_W] = CELL_BURNED;
                    end
                end
            end
            default:
            begin
                new_row = cur_row;
            end
        endcase
    end

    assign new_mask = burn_mask(new_row);

    always_comb
    begin
        for (int i = 0; i < GRID_SIZE; i++)
        begin
            rows_next[i] = rows_reg[i];
        end
        prev_next = prev_reg;
        burn_next = burn_reg;
        if (ctl.upd_step || ctl.emit_step)
        begin
            for (int i = 0; i < GRID_SIZE - 1; i++)
            begin
                rows_next[i] = rows_reg[i + 1];
            end
            rows_next[GRID_SIZE - 1] = ctl.upd_step ? new_row : cur_row;
        end
        if (ctl.upd_step)
        begin
            prev_next = cur_row;
            burn_next = (ctl.head ? 1'b0 : burn_reg) | (|new_mask);
        end
    end

    always_comb
    begin
        out_cells_next = '0;
        for (int j = 0; j < EMIT_COLS; j++)
        begin
            out_cells_next[j*CELL_W +: CELL_W] = cur_row[j*CELL_W +: CELL_W];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_SIZE; i++)
            begin
                rows_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < GRID_SIZE; i++)
            begin
                rows_reg[i] <= rows_next[i];
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        burn_reg <= burn_next;
        if (ctl.load)
        begin
            func_reg <= func;
            crow_reg <= cell_row;
            ccol_reg <= cell_col;
        end
        if (ctl.emit_load)
        begin
            out_idx_reg   <= FIELD_IDX_W'(row_idx);
            out_cells_reg <= out_cells_next;
            out_burn_reg  <= burn_reg;
            out_last_reg  <= ctl.emit_last;
        end
    end

    assign out_free        = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_row_index   = out_idx_reg;
    assign out_row_cells   = out_cells_reg;
    assign out_any_burning = out_burn_reg;
    assign out_last_row    = out_last_reg;

endmodule
